// ----- rtl/ptb_pkg.sv -----
// ptb_pkg: operation codes, status codes, controller state type and the
// command/status structs shared by the periodic timer bank modules.
// No dependencies.
`default_nettype none

package ptb_pkg;

	localparam int FUNC_W   = 3;
	localparam int TID_W    = 4;
	localparam int PERIOD_W = 16;
	localparam int STATUS_W = 2;
	localparam int FIRE_W   = 8;
	localparam int TPMS_W   = 8;
	localparam int CNT_W    = 16;

	localparam logic [CNT_W-1:0]  LIMIT_AT_RESET = 16'd1000;
	localparam logic [TPMS_W-1:0] TPMS_AT_RESET  = 8'd1;

	// operation codes
	localparam logic [FUNC_W-1:0] FN_TICK       = 3'd0;
	localparam logic [FUNC_W-1:0] FN_CLAIM      = 3'd1;
	localparam logic [FUNC_W-1:0] FN_SET_PERIOD = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SET_NOTIFY = 3'd3;
	localparam logic [FUNC_W-1:0] FN_UNCLAIM    = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ID      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CLAIMED     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_CLAIMED = 2'd3;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_RUN
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;   // capture the accepted word, clear the result
		logic exec;      // carry out a non-tick operation
		logic walk;      // advance the timer at the walk index
	} ptb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
	} ptb_stat_t;

endpackage

`default_nettype wire

// ----- rtl/ptb_in_if.sv -----
// ptb_in_if / ptb_out_if: valid/ready channels of the timer bank.
// Depends on ptb_pkg for field widths.
`default_nettype none

interface ptb_in_if
	import ptb_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [TID_W-1:0]    timer_id;
	logic [PERIOD_W-1:0] period;
	logic                notify_enable;

	modport source (output valid, func, timer_id, period, notify_enable, input ready);
	modport sink   (input valid, func, timer_id, period, notify_enable, output ready);
endinterface

interface ptb_out_if
	import ptb_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [FIRE_W-1:0]   fire_mask;

	modport source (output valid, status, fire_mask, input ready);
	modport sink   (input valid, status, fire_mask, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptb_ctrl.sv -----
// ptb_ctrl: controller state machine of the timer bank: handshakes, tick walk
// counter and result valid. Depends on ptb_pkg.
`default_nettype none

module ptb_ctrl
	import ptb_pkg::*;
#(
	parameter int NUM_TIMERS = 8,
	parameter int IDX_W      = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire ptb_stat_t        stat,
	output ptb_cmd_t              cmd,
	output logic [IDX_W-1:0]      walk_idx
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

	ctl_state_t       state_q, state_d;
	logic [IDX_W-1:0] walk_idx_q;
	logic             out_valid_q;
	logic             accept;
	logic             finish;
	logic             walk_last;

	// slot is free when empty or being taken this cycle
	assign in_ready  = (state_q == CS_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign walk_last = (walk_idx_q == LAST_IDX);
	assign out_valid = out_valid_q;
	assign walk_idx  = walk_idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (accept) state_d = CS_RUN;
			end
			CS_RUN: begin
				if (!stat.is_tick || walk_last) state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd    = '0;
		finish = 1'b0;
		case (state_q)
			CS_IDLE: begin
				cmd.load_in = accept;
			end
			CS_RUN: begin
				cmd.exec = !stat.is_tick;
				cmd.walk = stat.is_tick;
				finish   = !stat.is_tick || walk_last;
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			walk_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// walk counter
			if (finish) walk_idx_q <= '0;
			else if (cmd.walk) walk_idx_q <= walk_idx_q + IDX_W'(1);
			// result valid
			if (finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/ptb_dp.sv -----
// ptb_dp: datapath of the timer bank: captured word, per-timer state, limit
// multiplier and result registers. Depends on ptb_pkg.
`default_nettype none

module ptb_dp
	import ptb_pkg::*;
#(
	parameter int NUM_TIMERS = 8,
	parameter int IDX_W      = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [TPMS_W-1:0]   cfg_wdata,
	input  wire logic [FUNC_W-1:0]   in_func,
	input  wire logic [TID_W-1:0]    in_timer_id,
	input  wire logic [PERIOD_W-1:0] in_period,
	input  wire logic                in_notify_enable,
	input  wire ptb_cmd_t            cmd,
	input  wire logic [IDX_W-1:0]    walk_idx,
	output ptb_stat_t                stat,
	output logic [STATUS_W-1:0]      status,
	output logic [FIRE_W-1:0]        fire_mask
);

	// captured word
	logic [FUNC_W-1:0]   func_q;
	logic [TID_W-1:0]    id_q;
	logic [PERIOD_W-1:0] period_q;
	logic                nen_q;

	logic [TPMS_W-1:0]   tpms_q;
	logic [NUM_TIMERS-1:0] claimed_q;
	logic [NUM_TIMERS-1:0] notify_q;
	logic [CNT_W-1:0]    cnt_q [NUM_TIMERS];
	logic [CNT_W-1:0]    lim_q [NUM_TIMERS];

	logic [STATUS_W-1:0] status_q;
	logic [FIRE_W-1:0]   mask_q;

	logic                 id_ok;
	logic [IDX_W-1:0]     idx;
	logic [STATUS_W-1:0]  exec_status;
	logic                 do_write;
	logic [PERIOD_W+TPMS_W-1:0] product;
	logic [CNT_W-1:0]     new_limit;
	logic [CNT_W-1:0]     cnt_inc;
	logic                 expire;
	logic [FIRE_W-1:0]    fire_bit;

	assign stat.is_tick = (func_q == FN_TICK);
	assign status       = status_q;
	assign fire_mask    = mask_q;

	// id range check and guarded index
	assign id_ok = ({1'b0, id_q} < (TID_W+1)'(NUM_TIMERS));
	assign idx   = id_ok ? id_q[IDX_W-1:0] : '0;

	// limit = period * ticks_per_ms, low 16 bits
	assign product   = (PERIOD_W+TPMS_W)'(period_q) * (PERIOD_W+TPMS_W)'(tpms_q);
	assign new_limit = product[CNT_W-1:0];

	// status of a non-tick operation
	always_comb begin
		exec_status = ST_OK;
		case (func_q)
			FN_CLAIM: begin
				if (claimed_q[idx]) exec_status = ST_CLAIMED;
			end
			FN_SET_PERIOD, FN_SET_NOTIFY, FN_UNCLAIM: begin
				if (!claimed_q[idx]) exec_status = ST_NOT_CLAIMED;
			end
			default: exec_status = ST_OK;
		endcase
		if (!id_ok && (func_q == FN_CLAIM || func_q == FN_SET_PERIOD ||
		               func_q == FN_SET_NOTIFY || func_q == FN_UNCLAIM))
			exec_status = ST_BAD_ID;
	end
	assign do_write = cmd.exec && id_ok && (exec_status == ST_OK);

	// tick step for the timer at the walk index
	assign cnt_inc = cnt_q[walk_idx] + CNT_W'(1);
	assign expire  = (cnt_inc >= lim_q[walk_idx]);

	always_comb begin
		fire_bit = '0;
		for (int b = 0; b < FIRE_W; b++) begin
			if (b < NUM_TIMERS && walk_idx == IDX_W'(b)) fire_bit[b] = 1'b1;
		end
	end

	// captured word, no reset
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q   <= in_func;
			id_q     <= in_timer_id;
			period_q <= in_period;
			nen_q    <= in_notify_enable;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			status_q <= ST_OK;
			mask_q   <= '0;
		end else begin
			if (cmd.exec) status_q <= exec_status;
			if (cmd.walk && claimed_q[walk_idx] && expire && notify_q[walk_idx])
				mask_q <= mask_q | fire_bit;
		end
	end

	// config register and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpms_q    <= TPMS_AT_RESET;
			claimed_q <= '0;
			notify_q  <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				cnt_q[i] <= '0;
				lim_q[i] <= LIMIT_AT_RESET;
			end
		end else begin
			if (cfg_we) tpms_q <= cfg_wdata;
			if (cmd.walk && claimed_q[walk_idx]) begin
				cnt_q[walk_idx] <= expire ? '0 : cnt_inc;
			end
			if (do_write) begin
				case (func_q)
					FN_CLAIM: begin
						claimed_q[idx] <= 1'b1;
						lim_q[idx]     <= new_limit;
					end
					FN_SET_PERIOD: begin
						lim_q[idx] <= new_limit;
					end
					FN_SET_NOTIFY: begin
						notify_q[idx] <= nen_q;
					end
					FN_UNCLAIM: begin
						claimed_q[idx] <= 1'b0;
						notify_q[idx]  <= 1'b0;
						cnt_q[idx]     <= '0;
					end
					default: begin
						claimed_q <= claimed_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/periodic_timer_bank_core.sv -----
// periodic_timer_bank_core: claim, period, notify, unclaim: the word is captured at accept,
// executed in the run state, and the result is registered. Tick: the walk visits one timer
// per cycle in the run state. One word at a time: a new word is taken only when idle.
// Asynchronous reset: timers unclaimed, counts 0, limits 1000, ticks_per_ms 1.
// Depends on ptb_pkg, ptb_in_if/ptb_out_if, ptb_ctrl, ptb_dp.
`default_nettype none

module periodic_timer_bank_core
	import ptb_pkg::*;
#(
	parameter int NUM_TIMERS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TPMS_W-1:0] cfg_wdata,
	ptb_in_if.sink                 in_ch,
	ptb_out_if.source              out_ch
);

	localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

	ptb_cmd_t         cmd;
	ptb_stat_t        stat;
	logic [IDX_W-1:0] walk_idx;

	// controller
	ptb_ctrl #(
		.NUM_TIMERS (NUM_TIMERS),
		.IDX_W      (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.stat      (stat),
		.cmd       (cmd),
		.walk_idx  (walk_idx)
	);

	// datapath
	ptb_dp #(
		.NUM_TIMERS (NUM_TIMERS),
		.IDX_W      (IDX_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.in_func          (in_ch.func),
		.in_timer_id      (in_ch.timer_id),
		.in_period        (in_ch.period),
		.in_notify_enable (in_ch.notify_enable),
		.cmd              (cmd),
		.walk_idx         (walk_idx),
		.stat             (stat),
		.status           (out_ch.status),
		.fire_mask        (out_ch.fire_mask)
	);

endmodule

`default_nettype wire
